/* rtl/pdc_pkg.sv */
// ----------------------------------------------------------------------------
// pdc_pkg
// Shared types and constants of the pair distance cutoff classifier.
// ----------------------------------------------------------------------------
package pdc_pkg;

  localparam int TYPE_COUNT = 4;
  localparam int PAIR_COUNT = TYPE_COUNT * (TYPE_COUNT + 1) / 2;
  localparam int TYPE_W     = 2;
  localparam int PT_W       = 4;
  localparam int IDX_W      = 10;
  localparam int COORD_W    = 32;
  localparam int DIFF_W     = 35;  // shifted difference magnitude bound
  localparam int SQ_W       = 72;  // sum of three squares of 35-bit values
  localparam int ROOT_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CUTOFF_SQUARED  = 2'd0,
    REG_CUTOFF_DISABLED = 2'd1,
    REG_PERTURB_STEP    = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_REJECT = 2'd0,
    KIND_ENERGY = 2'd1,
    KIND_FORCE  = 2'd2
  } term_kind_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] first_z;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
    logic signed [COORD_W-1:0] second_z;
    logic [IDX_W-1:0]          first_index;
    logic [IDX_W-1:0]          second_index;
    logic                      second_is_ghost;
    logic [IDX_W-1:0]          force_index;
    logic [TYPE_W-1:0]         first_type;
    logic [TYPE_W-1:0]         second_type;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        term_kind;
    logic [ROOT_W-1:0] distance;
    logic [ROOT_W-1:0] distance_shift_x;
    logic [ROOT_W-1:0] distance_shift_y;
    logic [ROOT_W-1:0] distance_shift_z;
    logic [PT_W-1:0]   pair_type;
  } out_item_t;

  // start/busy control from the sequencer to a serial unit
  typedef struct packed {
    logic start;
    logic busy;
  } unit_ctl_t;

endpackage

/* rtl/pdc_if.sv */
// ----------------------------------------------------------------------------
// pdc_in_if / pdc_out_if / pdc_cfg_if
// Valid/ready channels of the classifier.
// ----------------------------------------------------------------------------
interface pdc_in_if;
  import pdc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pdc_out_if;
  import pdc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pdc_cfg_if;
  import pdc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/pair_distance_cutoff_classifier.sv */
// ----------------------------------------------------------------------------
// pair_distance_cutoff_classifier
// Squared distance, cutoff test, distances, force/energy class and type-pair histogram.
// ----------------------------------------------------------------------------
// One pair is handled at a time. A serial multiplier forms the three squares
// one bit per cycle and a radix-2 square root gives one distance bit per
// cycle. A rejected pair skips the root; for a force term three shifted sums
// and roots follow the base one on the same two units. The next item is taken
// as soon as the result moves into the output register.
module pair_distance_cutoff_classifier (
  input  logic       clk,
  input  logic       rst_n,
  pdc_in_if.sink     in_ch,
  pdc_out_if.source  out_ch,
  pdc_cfg_if.sink    cfg_ch
);
  import pdc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SQ   = 5'b00010,
    S_DEC  = 5'b00100,
    S_RT   = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r;
  logic [CFG_DATA_W-1:0] cutoff_r;
  logic                  disabled_r;
  logic [15:0]           step_r;
  logic [31:0]           counts_r [PAIR_COUNT];

  logic signed [DIFF_W-1:0] d_r [3];
  logic [1:0]               phase_r;  // 0 base, 1..3 shifted x,y,z
  logic                     ff_r;     // first particle moves
  logic [1:0]               kind_r;
  logic [PT_W-1:0]          pt_r;
  logic [ROOT_W-1:0]        dist_r [4];
  logic                     ovalid_r;
  out_item_t                odata_r;

  unit_ctl_t     sq_ctl, rt_ctl;
  logic          sq_done, rt_done;
  logic [SQ_W-1:0]   sq_sum;
  logic [ROOT_W-1:0] rt_root;
  logic [DIFF_W-1:0] mag [3];
  logic signed [DIFF_W-1:0] ds;

  logic in_fire, out_fire;
  logic [TYPE_W-1:0] thi, tlo;
  logic [PT_W-1:0]   pt_calc;
  logic accept, ff_c, sf_c;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  // magnitudes for the active phase: in a shifted phase one coordinate carries the step
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ds = d_r[k];
      if (phase_r != 2'd0 && int'(phase_r) == k + 1) begin
        ds = ff_r ? d_r[k] - DIFF_W'({1'b0, step_r})
                  : d_r[k] + DIFF_W'({1'b0, step_r});
      end
      mag[k] = ds[DIFF_W-1] ? DIFF_W'(-ds) : DIFF_W'(ds);
    end
  end

  always_comb begin
    thi = (in_ch.data.first_type > in_ch.data.second_type)
          ? in_ch.data.first_type : in_ch.data.second_type;
    tlo = (in_ch.data.first_type > in_ch.data.second_type)
          ? in_ch.data.second_type : in_ch.data.first_type;
    pt_calc = PT_W'((int'(thi) * (int'(thi) + 1)) / 2 + int'(tlo));
    ff_c = in_ch.data.first_index == in_ch.data.force_index;
    sf_c = !ff_c && !in_ch.data.second_is_ghost
           && in_ch.data.second_index == in_ch.data.force_index;
  end

  assign accept = disabled_r || (sq_sum[SQ_W-1:CFG_DATA_W] == '0
                                 && sq_sum[CFG_DATA_W-1:0] <= cutoff_r);

  assign sq_ctl.start = (state_r == S_SQ) && !sq_ctl.busy;
  // base root starts on an accepted pair, shifted roots as their sum ends
  assign rt_ctl.start = ((state_r == S_DEC) && accept)
                        || ((state_r == S_SQ) && sq_done && (phase_r != 2'd0));
  assign rt_ctl.busy  = (state_r == S_RT);

  logic sq_started_r;
  assign sq_ctl.busy = sq_started_r;

  pdc_sqsum u_sq (
    .clk, .rst_n, .ctl_in(sq_ctl), .mag_a(mag[0]), .mag_b(mag[1]),
    .mag_c(mag[2]), .done(sq_done), .sum(sq_sum)
  );

  pdc_isqrt u_rt (
    .clk, .rst_n, .ctl_in(rt_ctl), .value(sq_sum), .done(rt_done),
    .root(rt_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cutoff_r     <= '0;
      disabled_r   <= 1'b0;
      step_r       <= 16'd1;
      ovalid_r     <= 1'b0;
      sq_started_r <= 1'b0;
      for (int k = 0; k < PAIR_COUNT; k++) counts_r[k] <= '0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          REG_CUTOFF_SQUARED:  cutoff_r   <= cfg_ch.data;
          REG_CUTOFF_DISABLED: disabled_r <= cfg_ch.data[0];
          REG_PERTURB_STEP:    step_r     <= cfg_ch.data[15:0];
          default: ;
        endcase
      end
      if (out_fire) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            d_r[0]  <= DIFF_W'(in_ch.data.second_x) - DIFF_W'(in_ch.data.first_x);
            d_r[1]  <= DIFF_W'(in_ch.data.second_y) - DIFF_W'(in_ch.data.first_y);
            d_r[2]  <= DIFF_W'(in_ch.data.second_z) - DIFF_W'(in_ch.data.first_z);
            phase_r <= 2'd0;
            ff_r    <= ff_c;
            kind_r  <= (ff_c || sf_c) ? KIND_FORCE : KIND_ENERGY;
            pt_r    <= pt_calc;
            for (int k = 0; k < 4; k++) dist_r[k] <= '0;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          if (!sq_started_r) sq_started_r <= 1'b1;
          if (sq_done) begin
            sq_started_r <= 1'b0;
            state_r <= (phase_r == 2'd0) ? S_DEC : S_RT;
          end
        end
        S_DEC: begin
          if (accept) begin
            counts_r[pt_r] <= counts_r[pt_r] + 32'd1;
            state_r <= S_RT;
          end else begin
            kind_r  <= KIND_REJECT;
            state_r <= S_OUT;
          end
        end
        S_RT: begin
          if (rt_done) begin
            dist_r[phase_r] <= rt_root;
            if (kind_r == KIND_FORCE && phase_r != 2'd3) begin
              phase_r <= phase_r + 2'd1;
              state_r <= S_SQ;
            end else begin
              state_r <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (!ovalid_r || out_fire) begin
            ovalid_r <= 1'b1;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (state_r == S_OUT && (!ovalid_r || out_fire)) begin
      odata_r.term_kind        <= kind_r;
      odata_r.distance         <= dist_r[0];
      odata_r.distance_shift_x <= dist_r[1];
      odata_r.distance_shift_y <= dist_r[2];
      odata_r.distance_shift_z <= dist_r[3];
      odata_r.pair_type        <= pt_r;
    end
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = odata_r;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_SQ) else $error("item accepted outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(sq_ctl.start && rt_ctl.start)) else $error("two units started");
`endif

endmodule

/* rtl/pdc_sqsum.sv */
// ----------------------------------------------------------------------------
// pdc_sqsum
// Bit-serial sum of three squares: one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pdc_sqsum (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pdc_pkg::unit_ctl_t                 ctl_in,
  input  logic [pdc_pkg::DIFF_W-1:0]         mag_a,
  input  logic [pdc_pkg::DIFF_W-1:0]         mag_b,
  input  logic [pdc_pkg::DIFF_W-1:0]         mag_c,
  output logic                               done,
  output logic [pdc_pkg::SQ_W-1:0]           sum
);
  import pdc_pkg::*;

  localparam int CNT_W = $clog2(DIFF_W + 1);

  logic [DIFF_W-1:0] ma_r, mb_r, mc_r, sa_r, sb_r, sc_r;
  logic [SQ_W-1:0]   acc_r, acc_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic              run_r;
  logic [SQ_W-1:0]   pa, pb, pc;

  // shift-add: multiplicand doubles, multiplier is consumed from its lsb
  always_comb begin
    pa = sa_r[0] ? {{(SQ_W-DIFF_W){1'b0}}, ma_r} << cnt_r : '0;
    pb = sb_r[0] ? {{(SQ_W-DIFF_W){1'b0}}, mb_r} << cnt_r : '0;
    pc = sc_r[0] ? {{(SQ_W-DIFF_W){1'b0}}, mc_r} << cnt_r : '0;
    acc_nxt = acc_r + pa + pb + pc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done  <= 1'b0;
      cnt_r <= '0;
    end else begin
      done <= 1'b0;
      if (ctl_in.start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIFF_W - 1)) begin
          run_r <= 1'b0;
          done  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.start) begin
      ma_r <= mag_a; mb_r <= mag_b; mc_r <= mag_c;
      sa_r <= mag_a; sb_r <= mag_b; sc_r <= mag_c;
      acc_r <= '0;
    end else if (run_r) begin
      acc_r <= acc_nxt;
      sa_r <= sa_r >> 1;
      sb_r <= sb_r >> 1;
      sc_r <= sc_r >> 1;
    end
  end

  assign sum = acc_r;

endmodule

/* rtl/pdc_isqrt.sv */
// ----------------------------------------------------------------------------
// pdc_isqrt
// Digit-recurrence integer square root, one result bit per cycle, saturating.
// ----------------------------------------------------------------------------
module pdc_isqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pdc_pkg::unit_ctl_t           ctl_in,
  input  logic [pdc_pkg::SQ_W-1:0]     value,
  output logic                         done,
  output logic [pdc_pkg::ROOT_W-1:0]   root
);
  import pdc_pkg::*;

  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [2*ROOT_W-1:0] x_r;
  logic [ROOT_W+1:0]   rem_r, trial;
  logic [ROOT_W-1:0]   q_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                run_r, sat_r;

  // next two radicand bits enter the partial remainder each step
  always_comb begin
    trial = {rem_r[ROOT_W-1:0], x_r[2*ROOT_W-1 -: 2]} - {q_r, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done  <= 1'b0;
      cnt_r <= '0;
    end else begin
      done <= 1'b0;
      if (ctl_in.start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ROOT_W - 1)) begin
          run_r <= 1'b0;
          done  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.start) begin
      x_r   <= value[2*ROOT_W-1:0];
      sat_r <= |value[SQ_W-1:2*ROOT_W];
      rem_r <= '0;
      q_r   <= '0;
    end else if (run_r) begin
      x_r <= x_r << 2;
      if (!trial[ROOT_W+1]) begin
        rem_r <= trial;
        q_r   <= {q_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[ROOT_W-1:0], x_r[2*ROOT_W-1 -: 2]};
        q_r   <= {q_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign root = sat_r ? '1 : q_r;

endmodule
